>>> rtl/fan_tach_pulse_generator_unit_defines.svh
// Assertion macros shared by the fan tach pulse generator RTL.
// No dependencies; the checks drop out when SYNTHESIS is defined.
`ifndef FAN_TACH_PULSE_GENERATOR_UNIT_DEFINES_SVH
`define FAN_TACH_PULSE_GENERATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define FTPG_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("ftpg assertion failed");
`define FTPG_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("ftpg assertion failed");
`else
`define FTPG_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define FTPG_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

>>> rtl/ftpg_pkg.sv
// Shared types and constants of the fan tach pulse generator.
// Used by the interfaces, the divider and the top level.
package ftpg_pkg;

   localparam int RPM_W      = 16;
   localparam int DUTY_W     = 8;
   localparam int PERIOD_W   = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int DIV_STEPS   = PERIOD_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

   // Four tach edges per revolution: 60 s * 1e6 us / 4.
   localparam logic [PERIOD_W-1:0] US_PER_HALF_PERIOD_RPM = PERIOD_W'(15000000);

   // Division of the duty product by 255 as a reciprocal multiplication.
   // 255 * 16843010 = 2^32 + 254, so the product shifted down 32 bits is
   // floor(prod / 255) for every prod below 2^32 / 254, which covers 65535 * 255.
   localparam int RECIP_W     = 25;
   localparam int RECIP_SHIFT = 32;
   localparam int SCALE_W     = PERIOD_W + RECIP_W;
   localparam logic [RECIP_W-1:0] PWM_SCALE_RECIP = RECIP_W'(16843010);

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RPM    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AUTO_MODE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MANUAL_RPM = 2'd2;

   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_PWM  = 1'b1;

   typedef struct packed {
      logic                start;
      logic [PERIOD_W-1:0] dividend;
      logic [RPM_W-1:0]    divisor;
   } ftpg_div_req_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [PERIOD_W-1:0] quotient;
   } ftpg_div_rsp_type;

endpackage

>>> rtl/ftpg_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on ftpg_pkg for the field widths.
interface ftpg_req_if import ftpg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              mode;
   logic [DUTY_W-1:0] pwm_duty;

   modport source (output valid, output mode, output pwm_duty, input ready);
   modport sink (input valid, input mode, input pwm_duty, output ready);
endinterface

interface ftpg_rsp_if import ftpg_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             tach_level;
   logic [RPM_W-1:0] speed_rpm;

   modport source (output valid, output tach_level, output speed_rpm, input ready);
   modport sink (input valid, input tach_level, input speed_rpm, output ready);
endinterface

>>> rtl/ftpg_div.sv
// Restoring divider, one quotient bit per cycle, for the half-period division.
// Depends on ftpg_pkg for widths and the request/status structs.
module ftpg_div import ftpg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  ftpg_div_req_type div_req,
   output ftpg_div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RPM_W-1:0]     rem_ff, rem_in;
   logic [PERIOD_W-1:0]  quo_ff, quo_in;
   logic [RPM_W-1:0]     dsr_ff, dsr_in;

   logic [RPM_W:0] trial;
   logic [RPM_W:0] diff;
   logic           fits;

   // The dividend shifts out of the top of quo_ff while quotient bits enter below.
   assign trial = {rem_ff, quo_ff[PERIOD_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (busy_ff) begin
         rem_in = fits ? diff[RPM_W-1:0] : trial[RPM_W-1:0];
         quo_in = {quo_ff[PERIOD_W-2:0], fits};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

>>> rtl/fan_tach_pulse_generator_unit.sv
// Fan tach pulse generator: a tick item gives its result in the cycle after acceptance.
// A PWM item with nonzero speed goes in auto mode through reciprocal scaling,
// then a 24-step pass of the bit-serial divider; manual mode skips the scaling,
// and a zero speed skips the divider in either mode.
// One item at a time; the next is accepted in the cycle the result is taken.
// Synchronous active-high reset clears the control, speed, period and CSR state and sets auto mode.
`include "fan_tach_pulse_generator_unit_defines.svh"

module fan_tach_pulse_generator_unit import ftpg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ftpg_req_if.sink              req_if,
   ftpg_rsp_if.source            rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCALE,
      S_PERIOD,
      S_PERIOD_WAIT
   } state_type;

   state_type state_ff, state_in;

   logic [RPM_W-1:0]    max_rpm_ff;
   logic                auto_mode_ff;
   logic [RPM_W-1:0]    manual_rpm_ff;

   logic [RPM_W-1:0]    speed_ff, speed_in;
   logic [PERIOD_W-1:0] half_period_ff, half_period_in;
   logic [PERIOD_W-1:0] countdown_ff, countdown_in;
   logic                running_ff, running_in;
   logic                tach_ff, tach_in;
   logic [PERIOD_W-1:0] prod_ff, prod_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                req_accept;
   logic                respond;
   logic [PERIOD_W-1:0] cd_dec;
   logic [SCALE_W-1:0]  scaled;

   ftpg_div_req_type div_req;
   ftpg_div_rsp_type div_rsp;

   ftpg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_if.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign req_accept   = req_if.valid && req_if.ready;

   assign cd_dec = (countdown_ff != '0) ? countdown_ff - PERIOD_W'(1) : '0;

   assign scaled = SCALE_W'(prod_ff) * SCALE_W'(PWM_SCALE_RECIP);

   // The divider turns the speed into a half-period.
   always_comb begin
      div_req.start    = (state_ff == S_PERIOD) && (speed_ff != '0);
      div_req.dividend = US_PER_HALF_PERIOD_RPM;
      div_req.divisor  = speed_ff;
   end

   always_comb begin
      state_in       = state_ff;
      speed_in       = speed_ff;
      half_period_in = half_period_ff;
      countdown_in   = countdown_ff;
      running_in     = running_ff;
      tach_in        = tach_ff;
      prod_in        = prod_ff;
      respond        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_if.mode == MODE_PWM) begin
                  if (auto_mode_ff) begin
                     prod_in  = PERIOD_W'(max_rpm_ff) * PERIOD_W'(req_if.pwm_duty);
                     state_in = S_SCALE;
                  end else begin
                     speed_in = manual_rpm_ff;
                     state_in = S_PERIOD;
                  end
               end else begin
                  respond = 1'b1;
                  if (running_ff) begin
                     countdown_in = cd_dec;
                     if (cd_dec == '0) begin
                        tach_in      = ~tach_ff;
                        countdown_in = half_period_ff;
                     end
                  end
               end
            end
         end
         S_SCALE: begin
            speed_in = scaled[RECIP_SHIFT +: RPM_W];
            state_in = S_PERIOD;
         end
         S_PERIOD: begin
            if (speed_ff == '0) begin
               half_period_in = '0;
               countdown_in   = '0;
               running_in     = 1'b0;
               respond        = 1'b1;
               state_in       = S_IDLE;
            end else begin
               state_in = S_PERIOD_WAIT;
            end
         end
         S_PERIOD_WAIT: begin
            if (div_rsp.done) begin
               half_period_in = div_rsp.quotient;
               countdown_in   = div_rsp.quotient;
               running_in     = 1'b1;
               respond        = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (respond) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         speed_ff       <= '0;
         half_period_ff <= '0;
         countdown_ff   <= '0;
         running_ff     <= 1'b0;
         tach_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         speed_ff       <= speed_in;
         half_period_ff <= half_period_in;
         countdown_ff   <= countdown_in;
         running_ff     <= running_in;
         tach_ff        <= tach_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_rpm_ff    <= '0;
         auto_mode_ff  <= 1'b1;
         manual_rpm_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_RPM:    max_rpm_ff    <= csr_wdata[RPM_W-1:0];
            CSR_AUTO_MODE:  auto_mode_ff  <= csr_wdata[0];
            CSR_MANUAL_RPM: manual_rpm_ff <= csr_wdata[RPM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Result fields come straight from the state, which holds until the
   // next item is accepted.
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.tach_level = tach_ff;
   assign rsp_if.speed_rpm  = speed_ff;

   `FTPG_ASSERT_IMPLIES(a_running_count, clock, reset, running_ff,
      (countdown_ff != '0) && (countdown_ff <= half_period_ff))
   `FTPG_ASSERT_IMPLIES(a_stopped_clear, clock, reset, !running_ff,
      (countdown_ff == '0) && (half_period_ff == '0))
   `FTPG_ASSERT_NEXT(a_pwm_busy, clock, reset, req_accept && (req_if.mode == MODE_PWM),
      !req_if.ready && !rsp_valid_ff)
   `FTPG_ASSERT_IMPLIES(a_div_idle, clock, reset, state_ff == S_IDLE, !div_rsp.busy)

endmodule
